### hw/rtl/pkdf_pkg.sv
// shared types and constants for the per-key tick filter
package pkdf_pkg;
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    // the prime is 2^40 plus a 9-bit constant
    localparam int          FNV_PRIME_SH = 40;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam logic [31:0] CNT_MAX   = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        V_FWD  = 2'd0,
        V_DUP  = 2'd1,
        V_LATE = 2'd2,
        V_UNTR = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [63:0] symbol;
        logic [63:0] price;
        logic [62:0] timestamp;
        logic [63:0] hash;
    } t_job;
endpackage

### hw/rtl/per_key_dedup_reorder_filter_top.sv
// top level of the per-key duplicate and out-of-order tick filter
// usage:
//   raise start with a tick on i_symbol, i_price, i_timestamp; the transfer
//   happens on a clock edge where busy is low
//   each tick produces exactly one result, shown for one cycle with o_valid
//   the front hashes the symbol one byte per cycle, then hands the
//   job through a two-entry queue to the back, which reduces the hash to a
//   slot (from its low bits, or in four 16-bit chunks when the depth is not
//   a power of two) and probes the table, one registered read per probe
//   the front takes a new tick only after it has pushed the last one into
//   the queue; front and back overlap on consecutive ticks
//   verdict: 0 forwarded, 1 duplicate, 2 reordered, 3 forwarded untracked;
//   dropped ticks show zero payload; counters saturate at all ones
//   after reset the back clears the valid bits one entry per cycle; ticks
//   queue up meanwhile and busy holds the rest
//   the receiver cannot stall: results must be taken when o_valid is high
module per_key_dedup_reorder_filter_top
    import pkdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int PROBE_LIMIT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_symbol,
    input  logic [63:0] i_price,
    input  logic [62:0] i_timestamp,
    output logic        o_valid,
    output logic [1:0]  o_verdict,
    output logic [63:0] o_out_symbol,
    output logic [63:0] o_out_price,
    output logic [62:0] o_out_timestamp,
    output logic [31:0] o_forwarded_count,
    output logic [31:0] o_duplicate_count,
    output logic [31:0] o_reordered_count
);
    t_job w_fjob, w_qjob;
    logic w_push, w_pop, w_full, w_empty;

    pkdf_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_symbol, .i_price, .i_timestamp,
        .i_q_full(w_full), .o_busy(busy), .o_push(w_push), .o_job(w_fjob)
    );

    pkdf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_job(w_fjob), .i_pop(w_pop),
        .o_full(w_full), .o_empty(w_empty), .o_job(w_qjob)
    );

    pkdf_back #(.TABLE_DEPTH(TABLE_DEPTH), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_job(w_qjob), .o_pop(w_pop),
        .o_valid, .o_verdict, .o_out_symbol, .o_out_price,
        .o_out_timestamp, .o_forwarded_count, .o_duplicate_count,
        .o_reordered_count
    );
endmodule

### hw/rtl/pkdf_front.sv
// front end: accepts ticks and hashes the symbol one byte per cycle
module pkdf_front
    import pkdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_symbol,
    input  logic [63:0] i_price,
    input  logic [62:0] i_timestamp,
    input  logic        i_q_full,
    output logic        o_busy,
    output logic        o_push,
    output t_job        o_job
);
    typedef enum logic [1:0] {S_IDLE, S_HASH, S_PUSH} t_state;

    t_state      r_state;
    logic [2:0]  r_byte;
    logic [63:0] r_hash;
    logic [63:0] r_sym;
    logic [63:0] r_price;
    logic [62:0] r_ts;
    logic [63:0] n_hash;
    logic [63:0] w_mix;
    logic [7:0]  w_byte;

    // multiply by the prime as a 40-bit shift plus a small constant product
    always_comb begin
        w_byte = r_sym[r_byte*8 +: 8];
        w_mix  = r_hash ^ {56'd0, w_byte};
        n_hash = (w_mix << FNV_PRIME_SH) + 64'(w_mix * FNV_PRIME_LO);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_q_full;
    assign o_job  = '{symbol: r_sym, price: r_price, timestamp: r_ts, hash: r_hash};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_byte  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sym   <= i_symbol;
                        r_price <= i_price;
                        r_ts    <= i_timestamp;
                        r_hash  <= FNV_BASIS;
                        r_byte  <= '0;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_hash <= n_hash;
                    r_byte <= r_byte + 3'd1;
                    if (r_byte == 3'd7) r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_q_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/pkdf_queue.sv
// short job queue between front and back
module pkdf_queue
    import pkdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

### hw/rtl/pkdf_back.sv
// back end: probes the table, decides and updates entries and counters
module pkdf_back
    import pkdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int PROBE_LIMIT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    output logic [1:0]  o_verdict,
    output logic [63:0] o_out_symbol,
    output logic [63:0] o_out_price,
    output logic [62:0] o_out_timestamp,
    output logic [31:0] o_forwarded_count,
    output logic [31:0] o_duplicate_count,
    output logic [31:0] o_reordered_count
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(PROBE_LIMIT + 1);
    localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [31:0] DV    = 32'(TABLE_DEPTH);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MOD, S_FIX, S_READ, S_CHECK, S_DONE
    } t_state;

    t_state          r_state;
    logic            r_vld_mem  [TABLE_DEPTH];
    logic [63:0]     r_sym_mem  [TABLE_DEPTH];
    logic [63:0]     r_price_mem[TABLE_DEPTH];
    logic [62:0]     r_time_mem [TABLE_DEPTH];
    logic [63:0]     r_rd_sym;
    logic [63:0]     r_rd_price;
    logic [62:0]     r_rd_time;
    logic            r_rd_vld;
    t_job            r_job;
    logic [63:0]     r_hrem;
    logic [AW-1:0]   r_clr_addr;
    logic [1:0]      r_chunk;
    logic [15:0]     r_rem;
    logic [31:0]     r_mv;
    logic [15:0]     r_qest;
    logic [AW-1:0]   r_slot;
    logic [PW-1:0]   r_probe;
    logic [1:0]      r_verdict;
    logic [31:0]     r_fwd;
    logic [31:0]     r_dup;
    logic [31:0]     r_late;
    logic            r_out_vld;
    logic            r_we;
    logic [AW-1:0]   n_next;
    logic [AW:0]     w_inc;
    logic [31:0]     w_mv;
    logic [63:0]     w_prod;
    logic [31:0]     w_qd;
    logic [31:0]     w_r2;
    logic [31:0]     w_rem_nx;

    // next slot with wraparound
    always_comb begin
        w_inc  = {1'b0, r_slot} + {{AW{1'b0}}, 1'b1};
        n_next = (w_inc == (AW+1)'(TABLE_DEPTH)) ? '0 : w_inc[AW-1:0];
    end

    // hash mod depth, 16 bits at a time: reciprocal estimate in S_MOD, then
    // the estimate is low by at most one so a single subtract fixes it
    always_comb begin
        w_mv     = {r_rem, r_hrem[63:48]};
        w_prod   = {32'd0, w_mv} * {32'd0, RECIP};
        w_qd     = {16'd0, r_qest} * DV;
        w_r2     = r_mv - w_qd;
        w_rem_nx = (w_r2 >= DV) ? (w_r2 - DV) : w_r2;
    end

    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    // table memories, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_vld_mem[r_clr_addr] <= 1'b0;
        end else if (r_we) begin
            r_vld_mem[r_slot] <= 1'b1;
        end
        if (r_we) begin
            r_sym_mem[r_slot]   <= r_job.symbol;
            r_price_mem[r_slot] <= r_job.price;
            r_time_mem[r_slot]  <= r_job.timestamp;
        end
        r_rd_vld   <= r_vld_mem[r_slot];
        r_rd_sym   <= r_sym_mem[r_slot];
        r_rd_price <= r_price_mem[r_slot];
        r_rd_time  <= r_time_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fwd      <= '0;
            r_dup      <= '0;
            r_late     <= '0;
            r_out_vld  <= 1'b0;
            r_we       <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            r_we      <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // one valid bit per cycle after reset
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(TABLE_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_hrem  <= i_job.hash;
                        r_rem   <= '0;
                        r_chunk <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (POW2) begin
                        r_slot  <= r_hrem[AW-1:0];
                        r_probe <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_mv    <= w_mv;
                        r_qest  <= w_prod[47:32];
                        r_hrem  <= {r_hrem[47:0], 16'd0};
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_rem <= w_rem_nx[15:0];
                    if (r_chunk == 2'd3) begin
                        r_slot  <= w_rem_nx[AW-1:0];
                        r_probe <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_chunk <= r_chunk + 2'd1;
                        r_state <= S_MOD;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (!r_rd_vld) begin
                        r_we      <= 1'b1;
                        r_verdict <= V_FWD;
                        r_state   <= S_DONE;
                    end else if (r_rd_sym == r_job.symbol) begin
                        if (r_rd_price == r_job.price && r_rd_time == r_job.timestamp) begin
                            r_verdict <= V_DUP;
                        end else if (r_job.timestamp < r_rd_time) begin
                            r_verdict <= V_LATE;
                        end else begin
                            r_we      <= 1'b1;
                            r_verdict <= V_FWD;
                        end
                        r_state <= S_DONE;
                    end else if (r_probe == PW'(PROBE_LIMIT - 1)) begin
                        r_verdict <= V_UNTR;
                        r_state   <= S_DONE;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_slot  <= n_next;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    r_out_vld <= 1'b1;
                    unique case (r_verdict)
                        V_DUP:   if (r_dup != CNT_MAX) r_dup <= r_dup + 32'd1;
                        V_LATE:  if (r_late != CNT_MAX) r_late <= r_late + 32'd1;
                        default: if (r_fwd != CNT_MAX) r_fwd <= r_fwd + 32'd1;
                    endcase
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic w_pass;
    assign w_pass            = (r_verdict == V_FWD) || (r_verdict == V_UNTR);
    assign o_valid           = r_out_vld;
    assign o_verdict         = r_verdict;
    assign o_out_symbol      = w_pass ? r_job.symbol : '0;
    assign o_out_price       = w_pass ? r_job.price : '0;
    assign o_out_timestamp   = w_pass ? r_job.timestamp : '0;
    assign o_forwarded_count = r_fwd;
    assign o_duplicate_count = r_dup;
    assign o_reordered_count = r_late;
endmodule

### hw/rtl/pkdf_checker.sv
// port-level checker bound to the filter top level
module pkdf_checker
    import pkdf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_verdict,
    input logic [63:0] o_out_symbol,
    input logic [31:0] o_forwarded_count,
    input logic [31:0] o_duplicate_count,
    input logic [31:0] o_reordered_count
);
    // taken tick makes the front busy next cycle
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept not followed by busy");

    // a dropped tick shows no payload
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_verdict == V_DUP || o_verdict == V_LATE) |-> o_out_symbol == 64'd0)
        else $error("dropped tick carries payload");

    // counters never move without a result
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_valid) && !o_valid |-> $stable(o_forwarded_count)
            && $stable(o_duplicate_count) && $stable(o_reordered_count))
        else $error("counter moved without result");

    // results are single-cycle strobes
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held longer than one cycle");
endmodule

bind per_key_dedup_reorder_filter_top pkdf_checker u_pkdf_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_verdict, .o_out_symbol,
    .o_forwarded_count, .o_duplicate_count, .o_reordered_count
);

### tb/sv/tb_per_key_dedup_reorder_filter_checker.sv
// checker for the per-key tick filter: tracks the table, predicts each result, compares
`timescale 1ns / 100ps
module tb_per_key_dedup_reorder_filter_checker
    import pkdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int PROBE_LIMIT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [63:0] i_symbol,
    input  logic [63:0] i_price,
    input  logic [62:0] i_timestamp,
    input  logic        o_valid,
    input  logic [1:0]  o_verdict,
    input  logic [63:0] o_out_symbol,
    input  logic [63:0] o_out_price,
    input  logic [62:0] o_out_timestamp,
    input  logic [31:0] o_forwarded_count,
    input  logic [31:0] o_duplicate_count,
    input  logic [31:0] o_reordered_count,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct {
        t_verdict    verdict;
        logic [63:0] symbol;
        logic [63:0] price;
        logic [62:0] timestamp;
        logic [31:0] fwd_cnt;
        logic [31:0] dup_cnt;
        logic [31:0] late_cnt;
    } t_tick_result;

    logic        slot_used  [TABLE_DEPTH];
    logic [63:0] slot_sym   [TABLE_DEPTH];
    logic [63:0] slot_price [TABLE_DEPTH];
    logic [62:0] slot_time  [TABLE_DEPTH];
    logic [31:0] fwd_total, dup_total, late_total;
    t_tick_result expected_ticks[$];

    // fnv-1a over the symbol bytes, reduced to a table slot
    function automatic int unsigned home_slot(logic [63:0] sym);
        logic [63:0] h;
        h = FNV_BASIS;
        for (int b = 0; b < 8; b++) begin
            h = (h ^ {56'd0, sym[8*b +: 8]}) * FNV_PRIME;
        end
        return int'(h % TABLE_DEPTH);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

    task automatic filter_tick(logic [63:0] sym, logic [63:0] px, logic [62:0] ts);
        int unsigned  home, s, slot;
        bit           found, have_slot;
        t_tick_result r;
        home = home_slot(sym);
        found = 0;
        have_slot = 0;
        slot = 0;
        for (int p = 0; p < PROBE_LIMIT; p++) begin
            s = (home + p) % TABLE_DEPTH;
            if (!slot_used[s]) begin
                slot = s;
                have_slot = 1;
                break;
            end
            if (slot_sym[s] == sym) begin
                slot = s;
                have_slot = 1;
                found = 1;
                break;
            end
        end
        if (found && slot_price[slot] == px && slot_time[slot] == ts) begin
            r.verdict = V_DUP;
        end else if (found && ts < slot_time[slot]) begin
            r.verdict = V_LATE;
        end else if (have_slot) begin
            slot_used[slot]  = 1'b1;
            slot_sym[slot]   = sym;
            slot_price[slot] = px;
            slot_time[slot]  = ts;
            r.verdict = V_FWD;
        end else begin
            r.verdict = V_UNTR;
        end
        if (r.verdict == V_DUP) begin
            dup_total = sat_inc(dup_total);
        end else if (r.verdict == V_LATE) begin
            late_total = sat_inc(late_total);
        end else begin
            fwd_total = sat_inc(fwd_total);
        end
        // dropped ticks carry a zero payload
        if (r.verdict == V_FWD || r.verdict == V_UNTR) begin
            r.symbol = sym;
            r.price = px;
            r.timestamp = ts;
        end else begin
            r.symbol = '0;
            r.price = '0;
            r.timestamp = '0;
        end
        r.fwd_cnt = fwd_total;
        r.dup_cnt = dup_total;
        r.late_cnt = late_total;
        expected_ticks.push_back(r);
    endtask

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_tick_result r;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_used[i] = 1'b0;
            end
            fwd_total = '0;
            dup_total = '0;
            late_total = '0;
            expected_ticks.delete();
        end else begin
            if (o_valid) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: result with no tick waiting, expected none, actual verdict %0d",
                             $time, o_verdict);
                    o_fail_count++;
                end else begin
                    r = expected_ticks.pop_front();
                    if (o_verdict !== r.verdict) report("verdict", r.verdict, o_verdict);
                    if (o_out_symbol !== r.symbol) report("out_symbol", r.symbol, o_out_symbol);
                    if (o_out_price !== r.price) report("out_price", r.price, o_out_price);
                    if (o_out_timestamp !== r.timestamp)
                        report("out_timestamp", r.timestamp, o_out_timestamp);
                    if (o_forwarded_count !== r.fwd_cnt)
                        report("forwarded_count", r.fwd_cnt, o_forwarded_count);
                    if (o_duplicate_count !== r.dup_cnt)
                        report("duplicate_count", r.dup_cnt, o_duplicate_count);
                    if (o_reordered_count !== r.late_cnt)
                        report("reordered_count", r.late_cnt, o_reordered_count);
                end
            end
            if (start && !busy) filter_tick(i_symbol, i_price, i_timestamp);
        end
        o_pending = expected_ticks.size();
    end
endmodule

### tb/sv/tb_per_key_dedup_reorder_filter_top.sv
// testbench top for the per-key tick filter: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_per_key_dedup_reorder_filter_top;
    localparam int TABLE_DEPTH = 1024;
    localparam int POOL_SIZE   = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_symbol;
    logic [63:0] i_price;
    logic [62:0] i_timestamp;
    logic        o_valid;
    logic [1:0]  o_verdict;
    logic [63:0] o_out_symbol;
    logic [63:0] o_out_price;
    logic [62:0] o_out_timestamp;
    logic [31:0] o_forwarded_count;
    logic [31:0] o_duplicate_count;
    logic [31:0] o_reordered_count;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          idle_pct;

    logic [63:0] key_pool  [POOL_SIZE];
    logic [63:0] last_price[POOL_SIZE];
    logic [62:0] last_time [POOL_SIZE];

    per_key_dedup_reorder_filter_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

    tb_per_key_dedup_reorder_filter_checker #(.TABLE_DEPTH(TABLE_DEPTH)) chk (
        .i_clk, .i_rst_n, .start, .busy, .i_symbol, .i_price, .i_timestamp,
        .o_valid, .o_verdict, .o_out_symbol, .o_out_price, .o_out_timestamp,
        .o_forwarded_count, .o_duplicate_count, .o_reordered_count,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("per_key_dedup_reorder_filter_top regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random symbol whose hash lands on the given slot
    function automatic logic [63:0] key_homed_at(int unsigned slot);
        logic [63:0] k;
        do k = rand64(); while (chk.home_slot(k) != slot);
        return k;
    endfunction

    task automatic send_tick(logic [63:0] sym, logic [63:0] px, logic [62:0] ts);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_symbol <= sym;
        i_price <= px;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_pool_tick();
        int unsigned k, pick;
        logic [63:0] px;
        logic [62:0] ts;
        k = $urandom_range(POOL_SIZE - 1);
        pick = $urandom_range(99);
        px = last_price[k];
        ts = last_time[k];
        if (pick < 15) begin
            send_tick(rand64(), rand64(), 63'(rand64()));
            return;
        end else if (pick < 40) begin
            // repeat of the last price and latest time: duplicate if the table holds both
        end else if (pick < 55) begin
            ts = ts - $urandom_range(ts > 63'd1000 ? 32'd1000 : 32'(ts));
            if ($urandom_range(1)) px = rand64();
        end else begin
            ts = ts + $urandom_range(1000);
            if ($urandom_range(3) != 0) px = rand64();
            if ($urandom_range(9) == 0) ts = 63'(rand64());
        end
        last_price[k] = px;
        if (ts > last_time[k]) last_time[k] = ts;
        send_tick(key_pool[k], px, ts);
    endtask

    initial begin
        logic [63:0] crowd[5];
        int unsigned mid_slot;
        cycle_count = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_symbol = '0;
        i_price = '0;
        i_timestamp = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fresh insert, duplicate, older tick, same time new price, repeat of that
        send_tick(64'h0000_4C50_4141_5041, 64'd5, 63'd100);
        send_tick(64'h0000_4C50_4141_5041, 64'd5, 63'd100);
        send_tick(64'h0000_4C50_4141_5041, 64'd9, 63'd50);
        send_tick(64'h0000_4C50_4141_5041, 64'd6, 63'd100);
        send_tick(64'h0000_4C50_4141_5041, 64'd6, 63'd100);
        // field extremes
        send_tick(64'd0, 64'h8000_0000_0000_0000, 63'd0);
        send_tick(64'd0, 64'h8000_0000_0000_0000, 63'd0);
        send_tick('1, 64'h7FFF_FFFF_FFFF_FFFF, '1);
        send_tick('1, 64'h7FFF_FFFF_FFFF_FFFF, 63'd0);
        send_tick('1, '1, '1);
        // crowded window across the table end: four fill it, the fifth goes untracked
        for (int i = 0; i < 5; i++) crowd[i] = key_homed_at(TABLE_DEPTH - 2);
        for (int i = 0; i < 5; i++) send_tick(crowd[i], rand64(), 63'd10);
        send_tick(crowd[4], 64'd1, 63'd11);
        send_tick(crowd[3], 64'd2, 63'd20);
        send_tick(crowd[3], 64'd2, 63'd20);
        send_tick(crowd[0], 64'd3, 63'd5);

        // key pool: crowded groups plus ordinary keys
        mid_slot = $urandom_range(TABLE_DEPTH - 1);
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 5) key_pool[i] = crowd[i];
            else if (i < 11) key_pool[i] = key_homed_at(mid_slot);
            else key_pool[i] = rand64();
            last_price[i] = rand64();
            last_time[i] = 63'(rand64() >> ($urandom_range(40)));
        end

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 11 : (phase == 1) ? 84 : 0;
            repeat (330) send_pool_tick();
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("per_key_dedup_reorder_filter_top regression: pass");
        end else begin
            $display("per_key_dedup_reorder_filter_top regression: fail");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/pkdf_pkg.sv
hw/rtl/pkdf_front.sv
hw/rtl/pkdf_queue.sv
hw/rtl/pkdf_back.sv
hw/rtl/per_key_dedup_reorder_filter_top.sv
hw/rtl/pkdf_checker.sv
tb/sv/tb_per_key_dedup_reorder_filter_checker.sv
tb/sv/tb_per_key_dedup_reorder_filter_top.sv
